// ===== hw/rtl/wisd_pkg.sv =====
// ----------------------------------------------------------------------------
// wisd_pkg: shared types for the weighted interval scheduling unit
//
// Beat payloads for the request and response channels, plus the query and
// entry records that travel along the cell chain.
// ----------------------------------------------------------------------------
package wisd_pkg;

   localparam int TIME_W  = 16;
   localparam int PAY_W   = 16;
   localparam int TOTAL_W = 24;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   typedef struct packed {
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] end_time;
      logic [PAY_W-1:0]  pay;
      logic              first_of_set;
   } req_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] best_total;
      logic               dropped;
   } rsp_type;

   // A search walking down the chain: the start time it looks for and the
   // best total of the first (newest) compatible entry found so far.
   typedef struct packed {
      logic               valid;
      logic [TIME_W-1:0]  start_time;
      logic               found;
      logic [TOTAL_W-1:0] best;
   } query_type;

   // One stored task.
   typedef struct packed {
      logic [TIME_W-1:0]  end_time;
      logic [TOTAL_W-1:0] best;
   } entry_type;

endpackage

// ===== hw/rtl/wisd_cell.sv =====
// ----------------------------------------------------------------------------
// wisd_cell: one storage and compare cell of the task chain
//
// Holds one stored task and one stage of the search pipeline. On a shift the
// entry moves one cell further from the head, so cell 0 always holds the
// newest task.
// ----------------------------------------------------------------------------
module wisd_cell #(
   parameter int MAX_TASKS = 256,
   parameter int INDEX     = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        shift_en,
   input  logic [$clog2(MAX_TASKS+1)-1:0] count,
   input  wisd_pkg::query_type         prev_query,
   output wisd_pkg::query_type         next_query,
   input  wisd_pkg::entry_type         prev_entry,
   output wisd_pkg::entry_type         next_entry
);

   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   wisd_pkg::query_type query_ff, query_in;
   wisd_pkg::entry_type entry_ff, entry_in;
   logic                hit;

   // Only cells below the fill count hold live tasks.
   assign hit = prev_query.valid && !prev_query.found &&
                (CNT_W'(INDEX) < count) &&
                (entry_ff.end_time <= prev_query.start_time);

   always_comb begin
      query_in = prev_query;
      if (hit) begin
         query_in.found = 1'b1;
         query_in.best  = entry_ff.best;
      end
      entry_in = shift_en ? prev_entry : entry_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         query_ff <= '0;
      end else begin
         query_ff <= query_in;
      end
   end

   assign next_query = query_ff;
   assign next_entry = entry_ff;

endmodule

// ===== hw/rtl/weighted_interval_scheduling_dp_unit.sv =====
// ----------------------------------------------------------------------------
// weighted_interval_scheduling_dp_unit: streaming weighted interval scheduler
//
// Takes tasks in ascending end-time order and returns, per task, the best
// total pay over compatible tasks of the current set.
// ----------------------------------------------------------------------------
// The unit handles one task at a time. A stored task goes from its request
// beat through the search, then the pending register, then the output
// register; the next request is taken once that response is loaded, and a
// task dropped because the store is full skips the search. The search walks
// down a chain of MAX_TASKS cells, one cell per clock, looking for the newest
// stored task that ends at or before the new task's start. The response sits
// in an output register, so the next request is taken while an earlier
// response still waits for rsp_ready. A request with first_of_set high starts
// a new set; stored tasks need no clearing, since only cells below the fill
// count take part in a search.
module weighted_interval_scheduling_dp_unit #(
   parameter int MAX_TASKS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  wisd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wisd_pkg::rsp_type rsp_payload
);

   localparam int CNT_W   = $clog2(MAX_TASKS + 1);
   localparam int TOTAL_W = wisd_pkg::TOTAL_W;
   localparam int PAY_W   = wisd_pkg::PAY_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_OUT
   } state_type;

   state_type                    state_ff, state_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [PAY_W-1:0]             pay_ff, pay_in;
   logic [wisd_pkg::TIME_W-1:0]  end_ff, end_in;
   logic [TOTAL_W-1:0]           skip_ff, skip_in;
   wisd_pkg::rsp_type            pend_ff, pend_in;
   wisd_pkg::rsp_type            rsp_ff, rsp_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // The chain: link i feeds cell i, link i+1 is what cell i hands on.
   wisd_pkg::query_type link_query [MAX_TASKS+1];
   wisd_pkg::entry_type link_entry [MAX_TASKS+1];

   logic                         accept;
   logic                         full;
   logic                         done;
   logic                         rsp_free;
   logic [CNT_W-1:0]             count_eff;
   logic [CNT_W-1:0]             count_live;
   logic [TOTAL_W-1:0]           newest_best;
   logic [TOTAL_W:0]             sum;
   logic [TOTAL_W-1:0]           choose;
   logic [TOTAL_W-1:0]           best;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // A new set forgets the stored tasks by dropping the fill count.
   assign count_eff   = req_payload.first_of_set ? '0 : count_ff;
   assign full        = (count_eff >= CNT_W'(MAX_TASKS));
   assign newest_best = link_entry[1].best;

   // The head cell compares in the cycle of the request beat, before the fill
   // count register has taken a new set's zero, so it sees the count that
   // the request implies.
   assign count_live = (state_ff == S_IDLE) ? count_eff : count_ff;

   // The search leaves the last cell exactly once per stored task.
   assign done = (state_ff == S_SCAN) && link_query[MAX_TASKS].valid;

   always_comb begin
      link_query[0].valid      = accept && !full;
      link_query[0].start_time = req_payload.start_time;
      link_query[0].found      = 1'b0;
      link_query[0].best       = '0;
   end

   // Choose value saturates; on a tie the skip value stands.
   assign sum    = {1'b0, link_query[MAX_TASKS].best} + (TOTAL_W+1)'(pay_ff);
   assign choose = !link_query[MAX_TASKS].found ? TOTAL_W'(pay_ff) :
                   sum[TOTAL_W] ? wisd_pkg::TOTAL_MAX : sum[TOTAL_W-1:0];
   assign best   = (choose > skip_ff) ? choose : skip_ff;

   assign link_entry[0].end_time = end_ff;
   assign link_entry[0].best     = best;

   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      wisd_cell #(
         .MAX_TASKS(MAX_TASKS),
         .INDEX    (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (done),
         .count     (count_live),
         .prev_query(link_query[i]),
         .next_query(link_query[i+1]),
         .prev_entry(link_entry[i]),
         .next_entry(link_entry[i+1])
      );
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pay_in       = pay_ff;
      end_in       = end_ff;
      skip_in      = skip_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               count_in = count_eff;
               if (full) begin
                  // Store full: repeat the newest best total and flag it.
                  pend_in.best_total = newest_best;
                  pend_in.dropped    = 1'b1;
                  state_in           = S_OUT;
               end else begin
                  pay_in   = req_payload.pay;
                  end_in   = req_payload.end_time;
                  skip_in  = (count_eff != '0) ? newest_best : '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (done) begin
               pend_in.best_total = best;
               pend_in.dropped    = 1'b0;
               count_in           = count_ff + CNT_W'(1);
               state_in           = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pay_ff  <= pay_in;
      end_ff  <= end_in;
      skip_ff <= skip_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== hw/rtl/wisd_checker.sv =====
// ----------------------------------------------------------------------------
// wisd_checker: port-level checks for the scheduling unit
//
// Tracks beats in flight between the request and response channels.
// ----------------------------------------------------------------------------
module wisd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input wisd_pkg::rsp_type rsp_payload
);

   logic [1:0] pending_ff, pending_in;
   logic       req_beat;
   logic       rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_beat && !rsp_beat) begin
         pending_in = pending_ff + 2'd1;
      end else if (!req_beat && rsp_beat) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   a_one_task: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_ready)
      else $error("request taken while a task is in work");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response without a request");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 2'd2 |-> !req_ready)
      else $error("too many tasks in flight");

endmodule

bind weighted_interval_scheduling_dp_unit wisd_checker u_checker (.*);
